/* rtl/haversine_proximity_check_defines.svh */
// Assertion macros used by the checker file.
`ifndef HAVERSINE_PROXIMITY_CHECK_DEFINES_SVH
`define HAVERSINE_PROXIMITY_CHECK_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define HPC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HPC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/hpc_pkg.sv */
// Package with constants, tables and helpers of the haversine proximity check.
package hpc_pkg;
  localparam int CORDIC_STEPS_DEF = 32;
  localparam int MAX_STEPS = 40;
  localparam int QW = 36;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_REF_LAT = 3'd0;
  localparam logic [2:0] REG_REF_LON = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_MIN_DIST = 3'd3;
  localparam logic [2:0] REG_EXEMPT = 3'd4;

  localparam logic signed [34:0] TURN_HU = 35'sd7200000000;
  localparam logic signed [34:0] HALF_TURN_HU = 35'sd3600000000;
  localparam logic signed [34:0] QUARTER_TURN_HU = 35'sd1800000000;
  localparam logic signed [QW-1:0] GAIN_Q32 = 36'sd2608131496;
  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
  localparam logic [24:0] HALF_CIRC_M = 25'd20015087;
  localparam logic [23:0] EARTH_DIAM_M = 24'd12742000;
  // Pi in Q60 (Machin series) divided by 7.2e9 and rounded.
  localparam logic [28:0] RAD_SCALE = 29'd503056907;

  // Rounded arctangent of 2^-i in Q32; entries below precision use 2^(32-i), rounded.
  function automatic logic [32:0] atan_q32(input int i);
    logic [32:0] t [0:23];
    t = '{33'd3373259426, 33'd1991351318, 33'd1052175346, 33'd534100635,
          33'd268086748, 33'd134174063, 33'd67103403, 33'd33553749,
          33'd16777131, 33'd8388597, 33'd4194303, 33'd2097152,
          33'd1048576, 33'd524288, 33'd262144, 33'd131072, 33'd65536,
          33'd32768, 33'd16384, 33'd8192, 33'd4096, 33'd2048, 33'd1024,
          33'd512};
    if (i < 24) return t[i];
    if (i > 33) return '0;
    if (i == 33) return 33'd1;
    return 33'(64'd1 << (32 - i));
  endfunction

  typedef struct packed {
    logic [24:0] radius;
    logic [24:0] min_dist;
    logic        exempt;
  } hpc_cmp_t;

  typedef struct packed {
    logic signed [34:0] a_dlat;
    logic signed [34:0] a_dlon;
    logic signed [34:0] a_c1;
    logic signed [34:0] a_c2;
  } hpc_angles_t;
endpackage

/* rtl/hpc_trig.sv */
// Pipelined rotation CORDIC: reduces a half-unit angle and gives sine and cosine.
module hpc_trig import hpc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [34:0]   angle,
  output logic signed [QW-1:0] sin_q,
  output logic signed [QW-1:0] cos_q
);
  logic signed [QW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [QW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [QW-1:0] z_r [0:CORDIC_STEPS];
  logic                 f_r [0:CORDIC_STEPS];
  logic signed [34:0]   red_r;
  logic                 flip_r;
  logic signed [35:0]   w;
  logic signed [34:0]   red_nxt;
  logic                 flip_nxt;
  logic [33:0]          mag;
  logic [61:0]          prod;

  // Range reduction into plus/minus a quarter turn.
  always_comb begin
    w = 36'(angle);
    if (w >= 36'(HALF_TURN_HU)) w = w - 36'(TURN_HU);
    if (w < -36'(HALF_TURN_HU)) w = w + 36'(TURN_HU);
    flip_nxt = 1'b0;
    if (w > 36'(QUARTER_TURN_HU)) begin
      w = w - 36'(HALF_TURN_HU);
      flip_nxt = 1'b1;
    end else if (w < -36'(QUARTER_TURN_HU)) begin
      w = w + 36'(HALF_TURN_HU);
      flip_nxt = 1'b1;
    end
    red_nxt = 35'(w);
  end

  // Conversion to radians with a single multiply, registered into the first stage.
  assign mag  = red_r[34] ? 34'(-red_r) : 34'(red_r);
  assign prod = 62'(mag) * 62'(RAD_SCALE) + 62'(64'd1 << 26);

  always_ff @(posedge clk) begin
    if (en) begin
      red_r  <= red_nxt;
      flip_r <= flip_nxt;
      x_r[0] <= GAIN_Q32;
      y_r[0] <= '0;
      z_r[0] <= red_r[34] ? -QW'(prod >> 27) : QW'(prod >> 27);
      f_r[0] <= flip_r;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][QW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - QW'(atan_q32(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + QW'(atan_q32(i));
        end
      end
    end
  end

  assign sin_q = f_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  assign cos_q = f_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
endmodule

/* rtl/hpc_sqrt.sv */
// Pipelined bitwise square root: floor(sqrt(h * 2^32)), h in Q32; h of one or more gives one.
module hpc_sqrt import hpc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] h,
  output logic [32:0] root
);
  localparam int NS = 32;
  logic [65:0] v_r [0:NS];
  logic [32:0] r_r [0:NS];
  logic        sat_r [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= h[32];
      v_r[0]   <= {2'b00, h[31:0], 32'd0};
      r_r[0]   <= '0;
    end
  end

  // One result bit per stage, a compare and subtract on the remainder.
  for (genvar i = 0; i < NS; i++) begin : g_bit
    localparam int SH = 2 * (NS - 1 - i);
    logic [65:0] trial;
    assign trial = {31'd0, r_r[i], 2'b01} << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[i+1] <= sat_r[i];
        if (v_r[i] >= trial) begin
          v_r[i+1] <= v_r[i] - trial;
          r_r[i+1] <= {r_r[i][31:0], 1'b1};
        end else begin
          v_r[i+1] <= v_r[i];
          r_r[i+1] <= {r_r[i][31:0], 1'b0};
        end
      end
    end
  end

  assign root = sat_r[NS] ? Q32_ONE : r_r[NS];
endmodule

/* rtl/hpc_front.sv */
// Front end: takes points, forms the four angles and queues them with settings.
module hpc_front import hpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [30:0] ref_lat,
  input  logic signed [31:0] ref_lon,
  input  hpc_cmp_t           cmp_in,
  input  logic               take,
  output logic               avail,
  output hpc_angles_t        ang_out,
  output hpc_cmp_t           cmp_out
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  hpc_angles_t       q_ang [0:QUEUE_DEPTH-1];
  hpc_cmp_t          q_cmp [0:QUEUE_DEPTH-1];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  hpc_angles_t       a;
  logic              wr, rd;

  // Angles in half-units; the trig stage reduces them modulo a full turn.
  always_comb begin
    a.a_dlat = 35'(lat) - 35'(ref_lat);
    a.a_dlon = 35'(lon) - 35'(ref_lon);
    a.a_c1   = 35'(ref_lat) * 35'sd2;
    a.a_c2   = 35'(lat) * 35'sd2;
  end

  assign full  = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign avail = cnt_r != '0;
  assign wr    = push && !full;
  assign rd    = take && avail;
  assign ang_out = q_ang[rp_r];
  assign cmp_out = q_cmp[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      q_ang[wp_r] <= a;
      q_cmp[wp_r] <= cmp_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

/* rtl/hpc_back.sv */
// Back end: trig, haversine products, roots, arctangent and the output queue.
module hpc_back import hpc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        avail,
  output logic        take,
  input  hpc_angles_t ang,
  input  hpc_cmp_t    cmp,
  output logic        empty,
  input  logic        pop,
  output logic [24:0] distance,
  output logic        nearby,
  output logic        close
);
  localparam int LAT = 2 * CORDIC_STEPS + 41;
  localparam int OQ = LAT + 4;
  localparam int OAW = $clog2(OQ);

  logic en;
  logic [LAT-1:0] vld_r;
  hpc_cmp_t cmp_r [0:LAT-1];
  logic signed [QW-1:0] s_lat, s_lon, c1, c2, unused0, unused1, unused2, unused3;
  logic [OAW:0] cnt_r, inflight;
  logic [OAW-1:0] wp_r, rp_r;
  logic [26:0] oq_mem [0:OQ-1];

  // Issue only when the output queue has room for everything in flight.
  assign inflight = OAW'(0) + (OAW+1)'($countones(vld_r));
  assign en   = 1'b1;
  assign take = avail && (cnt_r + inflight) < (OAW+1)'(OQ);

  hpc_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_t0 (.clk, .en, .angle(ang.a_dlat),
    .sin_q(s_lat), .cos_q(unused0));
  hpc_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_t1 (.clk, .en, .angle(ang.a_dlon),
    .sin_q(s_lon), .cos_q(unused1));
  hpc_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_t2 (.clk, .en, .angle(ang.a_c1),
    .sin_q(unused2), .cos_q(c1));
  hpc_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_t3 (.clk, .en, .angle(ang.a_c2),
    .sin_q(unused3), .cos_q(c2));

  function automatic logic [31:0] mclamp(input logic signed [QW-1:0] v);
    logic [QW-1:0] m;
    m = v[QW-1] ? QW'(-v) : QW'(v);
    return (m > QW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  function automatic logic [32:0] mulq(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 33'((65'(p) + 65'(64'h8000_0000)) >> 32);
  endfunction

  function automatic logic [31:0] c32(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Haversine term over three registered stages: two multiply stages, then sum and clamp.
  logic [32:0] cc_r, sl2_r, sn2_r, term_r, hsl_r;
  logic        neg_r, neg2_r;
  logic signed [34:0] hsum;
  logic [32:0] hav_r, hinv;
  always_ff @(posedge clk) begin
    cc_r   <= mulq(mclamp(c1), mclamp(c2));
    neg_r  <= c1[QW-1] != c2[QW-1];
    sl2_r  <= mulq(mclamp(s_lon), mclamp(s_lon));
    sn2_r  <= mulq(mclamp(s_lat), mclamp(s_lat));
    term_r <= mulq(c32(cc_r), c32(sl2_r));
    hsl_r  <= sn2_r;
    neg2_r <= neg_r;
    hav_r  <= (hsum < 0) ? '0 : (hsum > 35'(Q32_ONE)) ? Q32_ONE : 33'(hsum);
  end
  assign hsum = neg2_r ? 35'(hsl_r) - 35'(term_r) : 35'(hsl_r) + 35'(term_r);
  assign hinv = Q32_ONE - hav_r;

  logic [32:0] ry, rx;
  hpc_sqrt u_sy (.clk, .en, .h(hav_r), .root(ry));
  hpc_sqrt u_sx (.clk, .en, .h(hinv), .root(rx));

  // Vectoring CORDIC for the half angle.
  logic signed [QW-1:0] vx_r [0:CORDIC_STEPS];
  logic signed [QW-1:0] vy_r [0:CORDIC_STEPS];
  logic signed [QW-1:0] vz_r [0:CORDIC_STEPS];
  always_ff @(posedge clk) begin
    vx_r[0] <= QW'(rx);
    vy_r[0] <= QW'(ry);
    vz_r[0] <= '0;
  end
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (vy_r[i] > 0) begin
        vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] + QW'(atan_q32(i));
      end else begin
        vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] - QW'(atan_q32(i));
      end
    end
  end

  // Scale to metres and saturate.
  logic [33:0] zc_r;
  logic [24:0] dist_r;
  logic [58:0] dprod;
  logic [26:0] dq;
  assign dprod = 59'(zc_r) * 59'(EARTH_DIAM_M) + 59'(64'h8000_0000);
  always_ff @(posedge clk) begin
    zc_r   <= vz_r[CORDIC_STEPS][QW-1] ? '0 : 34'(vz_r[CORDIC_STEPS]);
    dist_r <= (dprod[58:32] > 27'(HALF_CIRC_M)) ? HALF_CIRC_M : dprod[56:32];
  end

  // Compare against the settings carried alongside the item.
  hpc_cmp_t cl;
  logic w, c;
  assign cl = cmp_r[LAT-1];
  assign w  = cl.radius != '0 && dist_r <= cl.radius;
  assign c  = w && dist_r < cl.min_dist && !cl.exempt;
  assign dq = {dist_r, w, c};

  always_ff @(posedge clk) begin
    cmp_r[0] <= cmp;
    for (int k = 1; k < LAT; k++) cmp_r[k] <= cmp_r[k-1];
  end

  // Valid line and result queue; a head register holds the oldest result.
  logic rd, ld;
  logic [26:0] hd_r;
  logic        hd_vld_r;
  assign empty = !hd_vld_r;
  assign rd    = pop && hd_vld_r;
  assign ld    = (cnt_r != '0) && (!hd_vld_r || rd);
  always_ff @(posedge clk) begin
    if (vld_r[LAT-1]) oq_mem[wp_r] <= dq;
    if (ld) hd_r <= oq_mem[rp_r];
  end
  assign {distance, nearby, close} = hd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      cnt_r    <= '0;
      wp_r     <= '0;
      rp_r     <= '0;
      hd_vld_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], take};
      cnt_r <= cnt_r + (OAW+1)'(vld_r[LAT-1]) - (OAW+1)'(ld);
      if (vld_r[LAT-1]) wp_r <= (wp_r == OAW'(OQ-1)) ? '0 : wp_r + 1'b1;
      if (ld) rp_r <= (rp_r == OAW'(OQ-1)) ? '0 : rp_r + 1'b1;
      if (ld) hd_vld_r <= 1'b1;
      else if (rd) hd_vld_r <= 1'b0;
    end
  end
endmodule

/* rtl/haversine_proximity_check.sv */
// Haversine proximity check: one point per cycle while full is low and the
// output queue has room, fully pipelined through the two CORDIC pipelines
// (trig and arctangent) and the 32-stage root pipeline.
// Registers are sampled at transfer in, so writes apply to later points.
module haversine_proximity_check import hpc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [30:0] in_point_latitude,
  input  logic signed [31:0] in_point_longitude,
  output logic               empty,
  input  logic               pop,
  output logic [24:0]        out_distance_m,
  output logic               out_within_radius,
  output logic               out_too_close,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;
  hpc_cmp_t cmp_r, cmp_q;
  hpc_angles_t ang;
  logic avail, take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      cmp_r     <= '{radius: 25'd1000, min_dist: 25'd200, exempt: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_LAT:  ref_lat_r <= cfg_data[30:0];
        REG_REF_LON:  ref_lon_r <= cfg_data;
        REG_RADIUS:   cmp_r.radius <= cfg_data[24:0];
        REG_MIN_DIST: cmp_r.min_dist <= cfg_data[24:0];
        REG_EXEMPT:   cmp_r.exempt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hpc_front u_front (.clk, .rst_n, .push, .full, .lat(in_point_latitude),
    .lon(in_point_longitude), .ref_lat(ref_lat_r), .ref_lon(ref_lon_r),
    .cmp_in(cmp_r), .take, .avail, .ang_out(ang), .cmp_out(cmp_q));

  hpc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (.clk, .rst_n, .avail, .take,
    .ang, .cmp(cmp_q), .empty, .pop, .distance(out_distance_m),
    .nearby(out_within_radius), .close(out_too_close));
endmodule

/* rtl/hpc_checker.sv */
// Port-level checker for the haversine proximity check, bound to the top level.
`include "haversine_proximity_check_defines.svh"
module hpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [24:0] out_distance_m,
  input logic        out_within_radius,
  input logic        out_too_close
);
  `HPC_ASSERT_IMP(a_close_in, clk, rst_n, !empty && out_too_close, out_within_radius)
  `HPC_ASSERT_IMP(a_sat, clk, rst_n, !empty, out_distance_m <= 25'd20015087)
  `HPC_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_distance_m))
endmodule

bind haversine_proximity_check hpc_checker u_chk (.clk, .rst_n, .empty, .pop,
  .out_distance_m, .out_within_radius, .out_too_close);
